// ----- rtl/mqtt_packet_field_parser_defines.svh -----
// ----------------------------------------------------------------------------
// MQTT packet field parser assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MQTT_PACKET_FIELD_PARSER_DEFINES_SVH
`define MQTT_PACKET_FIELD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MPFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mpfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define MPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mpfp: next-cycle check failed");

`endif

// ----- rtl/mpfp_pkg.sv -----
// ----------------------------------------------------------------------------
// MQTT packet field parser package
// Field kinds, packet type codes and helpers shared by the parser files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpfp_pkg;

  // Widths of the stream fields
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned VALUE_W   = 28;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned OUT_DATA_W = 40;

  // Default number of remaining-length bytes before overflow
  localparam int unsigned MAX_LENGTH_BYTES = 4;

  // Field kinds reported on the result stream
  localparam logic [KIND_W-1:0] KIND_HEADER    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LENGTH    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_CONNFLAGS = 4'd2;
  localparam logic [KIND_W-1:0] KIND_KEEPALIVE = 4'd3;
  localparam logic [KIND_W-1:0] KIND_CLIENT_LEN = 4'd4;
  localparam logic [KIND_W-1:0] KIND_TOPIC_LEN = 4'd9;
  localparam logic [KIND_W-1:0] KIND_PKTID     = 4'd10;
  localparam logic [KIND_W-1:0] KIND_STRBYTE   = 4'd11;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_QOS       = 4'd13;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 4'd14;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 4'd15;

  // Values carried with the format error kind
  localparam logic [VALUE_W-1:0] ERR_UNSUPPORTED = 28'd1;
  localparam logic [VALUE_W-1:0] ERR_CUT_FIELD   = 28'd2;

  // Control packet types
  localparam logic [NIBBLE_W-1:0] TYPE_CONNECT     = 4'd1;
  localparam logic [NIBBLE_W-1:0] TYPE_PUBLISH     = 4'd3;
  localparam logic [NIBBLE_W-1:0] TYPE_PUBACK      = 4'd4;
  localparam logic [NIBBLE_W-1:0] TYPE_SUBSCRIBE   = 4'd8;
  localparam logic [NIBBLE_W-1:0] TYPE_UNSUBSCRIBE = 4'd10;
  localparam logic [NIBBLE_W-1:0] TYPE_PINGREQ     = 4'd12;
  localparam logic [NIBBLE_W-1:0] TYPE_DISCONNECT  = 4'd14;

  // True for the packet types that the parser decodes
  function automatic logic type_supported(input logic [NIBBLE_W-1:0] t);
    return (t == TYPE_CONNECT) || (t == TYPE_PUBLISH) ||
           ((t >= TYPE_PUBACK) && (t <= TYPE_SUBSCRIBE)) ||
           (t == TYPE_UNSUBSCRIBE) ||
           ((t >= TYPE_PINGREQ) && (t <= TYPE_DISCONNECT));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mqtt_packet_field_parser.sv -----
// ----------------------------------------------------------------------------
// MQTT packet field parser
// Splits a received MQTT 3.1.1 byte stream into header, length and body
// fields, one optional result per byte.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Width  Contents
//  s_axis    in   8      tdata: data_byte
//  m_axis    out  40     tdata: field_value, packet_type, header_flags;
//                        tuser: field_kind; tlast: last
//
//  One byte per cycle sustained while results are taken; a byte's result
//  passes from the input register through the parse step into the result
//  register. The parse step is a single state update between the input and
//  result registers; bytes that yield no field leave no result.
//  Reset returns the parser to expect a fixed header.
//  A stalled result holds the result register; a byte already in the input
//  register waits, and an empty input register takes one more byte before
//  tready drops.
//
`timescale 1ns / 1ps
`default_nettype none

module mqtt_packet_field_parser #(
  parameter int unsigned MAX_LENGTH_BYTES = mpfp_pkg::MAX_LENGTH_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // fields from bit 0: data_byte[7:0]
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // fields from bit 0: field_value[27:0], packet_type[31:28],
  // header_flags[35:32], zero[39:36]
  output logic [39:0]      m_axis_tdata_o,
  // fields from bit 0: field_kind[3:0]
  output logic [3:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i
);

  localparam int unsigned BW = mpfp_pkg::BYTE_W;
  localparam int unsigned VW = mpfp_pkg::VALUE_W;
  localparam int unsigned NW = mpfp_pkg::NIBBLE_W;
  localparam int unsigned KW = mpfp_pkg::KIND_W;
  localparam int unsigned PAD_W = mpfp_pkg::OUT_DATA_W - VW - 2 * NW;

  // String slots
  localparam logic [2:0] SLOT_CLIENT   = 3'd0;
  localparam logic [2:0] SLOT_WILL_TOP = 3'd1;
  localparam logic [2:0] SLOT_WILL_MSG = 3'd2;
  localparam logic [2:0] SLOT_USER     = 3'd3;
  localparam logic [2:0] SLOT_PASS     = 3'd4;
  localparam logic [2:0] SLOT_TOPIC    = 3'd5;
  localparam logic [2:0] SLOT_FILTER   = 3'd6;

  // Connect flag bits
  localparam int unsigned CF_WILL = 2;
  localparam int unsigned CF_PASS = 6;
  localparam int unsigned CF_USER = 7;

  // Protocol name and level bytes ahead of the connect flags
  localparam logic [2:0] PROTO_BYTES = 3'd7;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_LEN,
    PH_SKIP,
    PH_PROTO,
    PH_CFLAGS,
    PH_KA_H,
    PH_KA_L,
    PH_STR_H,
    PH_STR_L,
    PH_STR_BODY,
    PH_PID_H,
    PH_PID_L,
    PH_PAYLOAD,
    PH_QOS
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] slot;
  } next_t;

  // Input register
  logic          in_valid_q;
  logic [BW-1:0] in_byte_q;
  logic          advance;

  // Parser state
  phase_e        phase_q, phase_d;
  logic [2:0]    slot_q, slot_d;
  logic [NW-1:0] type_q, type_d;
  logic [NW-1:0] flags_q, flags_d;
  logic [VW-1:0] len_acc_q, len_acc_d;
  logic [2:0]    len_cnt_q, len_cnt_d;
  logic [VW-1:0] body_left_q, body_left_d;
  logic [BW-1:0] cflags_q, cflags_d;
  logic [BW-1:0] high_q, high_d;
  logic [15:0]   str_left_q, str_left_d;
  logic [2:0]    skip_q, skip_d;

  // Result register
  logic          out_valid_q;
  logic [KW-1:0] out_kind_q;
  logic [VW-1:0] out_value_q;
  logic [NW-1:0] out_type_q;
  logic [NW-1:0] out_flags_q;
  logic          out_last_q;

  // Result of the current step
  logic          have;
  logic [KW-1:0] kind;
  logic [VW-1:0] value;
  logic          last;

  // Step helpers
  logic [VW-1:0] len_add;
  logic [15:0]   word;
  logic [15:0]   str_dec;
  next_t         after;

  // Phase after a finished string of the given slot
  function automatic next_t after_string(input logic [2:0] slot, input logic [BW-1:0] cf,
                                         input logic [NW-1:0] t, input logic [NW-1:0] f);
    next_t n;
    n.phase = PH_SKIP;
    n.slot  = slot;
    case (slot)
      SLOT_CLIENT, SLOT_WILL_MSG, SLOT_USER: begin
        if (slot == SLOT_CLIENT && cf[CF_WILL]) begin
          n.phase = PH_STR_H;
          n.slot  = SLOT_WILL_TOP;
        end else if (slot != SLOT_USER && cf[CF_USER]) begin
          n.phase = PH_STR_H;
          n.slot  = SLOT_USER;
        end else if (cf[CF_PASS]) begin
          n.phase = PH_STR_H;
          n.slot  = SLOT_PASS;
        end
      end
      SLOT_WILL_TOP: begin
        n.phase = PH_STR_H;
        n.slot  = SLOT_WILL_MSG;
      end
      SLOT_TOPIC: begin
        n.phase = (f[2:1] != 2'd0) ? PH_PID_H : PH_PAYLOAD;
      end
      SLOT_FILTER: begin
        n.phase = (t == mpfp_pkg::TYPE_SUBSCRIBE) ? PH_QOS : PH_STR_H;
      end
      default: begin
        n.phase = PH_SKIP;
      end
    endcase
    return n;
  endfunction

  // Move a byte on when the result register is free or drains now
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Shifted length digit
  always_comb begin
    len_add = '0;
    case (len_cnt_q[1:0])
      2'd0:    len_add = VW'(in_byte_q[6:0]);
      2'd1:    len_add = VW'(in_byte_q[6:0]) << 7;
      2'd2:    len_add = VW'(in_byte_q[6:0]) << 14;
      default: len_add = VW'(in_byte_q[6:0]) << 21;
    endcase
  end

  assign word    = {high_q, in_byte_q};
  assign str_dec = str_left_q - 16'd1;
  assign after   = after_string(slot_q, cflags_q, type_q, flags_q);

  // Parse one byte
  always_comb begin
    phase_d     = phase_q;
    slot_d      = slot_q;
    type_d      = type_q;
    flags_d     = flags_q;
    len_acc_d   = len_acc_q;
    len_cnt_d   = len_cnt_q;
    body_left_d = body_left_q;
    cflags_d    = cflags_q;
    high_d      = high_q;
    str_left_d  = str_left_q;
    skip_d      = skip_q;
    have        = 1'b0;
    kind        = mpfp_pkg::KIND_HEADER;
    value       = '0;
    last        = 1'b0;

    case (phase_q)
      PH_HDR: begin
        type_d    = in_byte_q[7:4];
        flags_d   = in_byte_q[3:0];
        len_acc_d = '0;
        len_cnt_d = '0;
        have      = 1'b1;
        phase_d   = PH_LEN;
        if (mpfp_pkg::type_supported(in_byte_q[7:4])) begin
          kind  = mpfp_pkg::KIND_HEADER;
          value = VW'(in_byte_q);
        end else begin
          kind  = mpfp_pkg::KIND_ERROR;
          value = mpfp_pkg::ERR_UNSUPPORTED;
        end
      end
      PH_LEN: begin
        len_acc_d = len_acc_q + len_add;
        len_cnt_d = len_cnt_q + 3'd1;
        value     = len_acc_d;
        if (in_byte_q[7]) begin
          if (32'(len_cnt_d) >= MAX_LENGTH_BYTES) begin
            have    = 1'b1;
            kind    = mpfp_pkg::KIND_OVERFLOW;
            last    = 1'b1;
            phase_d = PH_HDR;
          end
        end else begin
          have        = 1'b1;
          kind        = mpfp_pkg::KIND_LENGTH;
          body_left_d = len_acc_d;
          if (len_acc_d == '0) begin
            last    = 1'b1;
            phase_d = PH_HDR;
          end else if (type_q == mpfp_pkg::TYPE_CONNECT) begin
            skip_d  = '0;
            phase_d = PH_PROTO;
          end else if (type_q == mpfp_pkg::TYPE_PUBLISH) begin
            phase_d = PH_STR_H;
            slot_d  = SLOT_TOPIC;
          end else if ((type_q >= mpfp_pkg::TYPE_PUBACK &&
                        type_q <= mpfp_pkg::TYPE_SUBSCRIBE) ||
                       type_q == mpfp_pkg::TYPE_UNSUBSCRIBE) begin
            phase_d = PH_PID_H;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      default: begin
        body_left_d = body_left_q - VW'(1);
        case (phase_q)
          PH_PROTO: begin
            skip_d = skip_q + 3'd1;
            if (skip_d == PROTO_BYTES) begin
              phase_d = PH_CFLAGS;
            end
          end
          PH_CFLAGS: begin
            cflags_d = in_byte_q;
            have     = 1'b1;
            kind     = mpfp_pkg::KIND_CONNFLAGS;
            value    = VW'(in_byte_q);
            phase_d  = PH_KA_H;
          end
          PH_KA_H: begin
            high_d  = in_byte_q;
            phase_d = PH_KA_L;
          end
          PH_PID_H: begin
            high_d  = in_byte_q;
            phase_d = PH_PID_L;
          end
          PH_KA_L: begin
            have    = 1'b1;
            kind    = mpfp_pkg::KIND_KEEPALIVE;
            value   = VW'(word);
            phase_d = PH_STR_H;
            slot_d  = SLOT_CLIENT;
          end
          PH_PID_L: begin
            have  = 1'b1;
            kind  = mpfp_pkg::KIND_PKTID;
            value = VW'(word);
            if (type_q == mpfp_pkg::TYPE_PUBLISH) begin
              phase_d = PH_PAYLOAD;
            end else if (type_q == mpfp_pkg::TYPE_SUBSCRIBE ||
                         type_q == mpfp_pkg::TYPE_UNSUBSCRIBE) begin
              phase_d = PH_STR_H;
              slot_d  = SLOT_FILTER;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          PH_PAYLOAD: begin
            have  = 1'b1;
            kind  = mpfp_pkg::KIND_PAYLOAD;
            value = VW'(in_byte_q);
          end
          PH_QOS: begin
            have    = 1'b1;
            kind    = mpfp_pkg::KIND_QOS;
            value   = VW'(in_byte_q);
            phase_d = PH_STR_H;
            slot_d  = SLOT_FILTER;
          end
          PH_STR_H: begin
            high_d  = in_byte_q;
            phase_d = PH_STR_L;
          end
          PH_STR_L: begin
            str_left_d = word;
            have       = 1'b1;
            kind       = (slot_q <= SLOT_PASS) ? mpfp_pkg::KIND_CLIENT_LEN + KW'(slot_q)
                                               : mpfp_pkg::KIND_TOPIC_LEN;
            value      = VW'(word);
            if (word == 16'd0) begin
              phase_d = after.phase;
              slot_d  = after.slot;
            end else begin
              phase_d = PH_STR_BODY;
            end
          end
          PH_STR_BODY: begin
            have       = 1'b1;
            kind       = mpfp_pkg::KIND_STRBYTE;
            value      = VW'(in_byte_q);
            str_left_d = str_dec;
            if (str_dec == 16'd0) begin
              phase_d = after.phase;
              slot_d  = after.slot;
            end
          end
          default: begin
            // skipped body byte
          end
        endcase
        // Close the packet on its final body byte
        if (body_left_d == '0) begin
          if (!have) begin
            have  = 1'b1;
            kind  = mpfp_pkg::KIND_ERROR;
            value = mpfp_pkg::ERR_CUT_FIELD;
          end
          last    = 1'b1;
          phase_d = PH_HDR;
        end
      end
    endcase
  end

  // Hold input byte, parser state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_byte_q   <= '0;
      phase_q     <= PH_HDR;
      slot_q      <= SLOT_CLIENT;
      type_q      <= '0;
      flags_q     <= '0;
      len_acc_q   <= '0;
      len_cnt_q   <= '0;
      body_left_q <= '0;
      cflags_q    <= '0;
      high_q      <= '0;
      str_left_q  <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= '0;
      out_value_q <= '0;
      out_type_q  <= '0;
      out_flags_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // take a new byte whenever the input register frees up
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
        if (s_axis_tvalid_i) begin
          in_byte_q <= s_axis_tdata_i;
        end
      end
      if (advance) begin
        phase_q     <= phase_d;
        slot_q      <= slot_d;
        type_q      <= type_d;
        flags_q     <= flags_d;
        len_acc_q   <= len_acc_d;
        len_cnt_q   <= len_cnt_d;
        body_left_q <= body_left_d;
        cflags_q    <= cflags_d;
        high_q      <= high_d;
        str_left_q  <= str_left_d;
        skip_q      <= skip_d;
        out_valid_q <= have;
        if (have) begin
          out_kind_q  <= kind;
          out_value_q <= value;
          out_type_q  <= type_d;
          out_flags_q <= flags_d;
          out_last_q  <= last;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_flags_q, out_type_q, out_value_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/mpfp_checker.sv -----
// ----------------------------------------------------------------------------
// MQTT packet field parser port checker
// Watches the result stream of the parser for handshake and field rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mqtt_packet_field_parser_defines.svh"

module mpfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic [39:0] m_axis_tdata_i,
  input wire logic [3:0]  m_axis_tuser_i,
  input wire logic        m_axis_tlast_i,
  input wire logic        m_axis_tvalid_i,
  input wire logic        m_axis_tready_i
);

  logic        stalled;
  logic        cut_error;
  logic        is_header;
  logic        is_overflow;
  logic        header_ok;
  logic [44:0] beat;

  assign stalled     = m_axis_tvalid_i && !m_axis_tready_i;
  assign cut_error   = (m_axis_tuser_i == mpfp_pkg::KIND_ERROR) &&
                       (m_axis_tdata_i[27:0] == mpfp_pkg::ERR_CUT_FIELD);
  assign is_header   = m_axis_tvalid_i && (m_axis_tuser_i == mpfp_pkg::KIND_HEADER);
  assign is_overflow = m_axis_tvalid_i && (m_axis_tuser_i == mpfp_pkg::KIND_OVERFLOW);
  assign header_ok   = (m_axis_tdata_i[7:4] == m_axis_tdata_i[31:28]) &&
                       (m_axis_tdata_i[3:0] == m_axis_tdata_i[35:32]) &&
                       (m_axis_tdata_i[27:8] == 20'd0);
  assign beat        = {m_axis_tlast_i, m_axis_tuser_i, m_axis_tdata_i};

  // Stalled result holds its contents
  `MPFP_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stalled, m_axis_tvalid_i && $stable(beat))

  // Length overflow always ends the packet
  `MPFP_ASSERT_NOW(a_overflow_last, clk_i, rst_ni, is_overflow, m_axis_tlast_i)

  // A field cut by the end of the body ends the packet
  `MPFP_ASSERT_NOW(a_cut_last, clk_i, rst_ni, m_axis_tvalid_i && cut_error, m_axis_tlast_i)

  // Header byte agrees with the reported type and flags
  `MPFP_ASSERT_NOW(a_header_fields, clk_i, rst_ni, is_header, header_ok)

endmodule

bind mqtt_packet_field_parser mpfp_checker u_mpfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire
